// ===== src/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache table: request and response
// layouts, operation codes, learn status codes and the entry write bundle.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int TTL_W         = 8;

    localparam logic [TTL_W-1:0] LIFETIME_RST = 8'd16;
    localparam logic [MAC_W-1:0] MAC_BCAST    = '1;
    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        FN_LEARN  = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_TICK   = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        LS_REFRESH = 2'd0,
        LS_INSERT  = 2'd1,
        LS_FULL    = 2'd2
    } t_lstat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_func             func;
        logic [IP_W-1:0]   ip_addr;
        logic [IP_W-1:0]   next_hop_ip;
        logic [MAC_W-1:0]  mac_addr;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  dest_mac;
        logic [1:0]        learn_status;
    } t_rsp;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TTL_W-1:0]  ttl;
    } t_entry;

    typedef struct packed {
        logic              ip_we;
        logic              mac_we;
        logic              ttl_we;
        logic [IDX_W-1:0]  idx;
        t_entry            data;
    } t_wr;

endpackage

// ===== src/arp_cache_table.sv =====
// ----------------------------------------------------------------------------
// arp_cache_table
// IP-to-MAC cache with a per-entry lifetime: learn, lookup and aging tick.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_req and pulse i_start while o_busy is low; the request is taken
//   at that edge. func selects learn, lookup, aging tick or no-op.
//   One sequencer walks the entries one per cycle through a single IP
//   comparator and lifetime decrementer. Learn and lookup stop at the first
//   matching entry; a tick or a miss walks all TABLE_ENTRIES entries.
//   The result appears on o_rsp and o_done is high for exactly one cycle.
//   After the accepting edge the sequencer visits entries in the scan state,
//   then passes the finish state, which registers the response and strobe;
//   a no-op goes from idle straight to the finish state.
//   o_busy is low in the cycle the result shows, so requests can follow
//   with no gap beyond that. The receiver cannot stall; it must take each
//   result in its strobe cycle.
//   i_cfg_we / i_cfg_wdata load the lifetime given to learned entries;
//   write it only while no request is in flight.
//   Synchronous reset clears every entry to zero, sets the lifetime to 16
//   and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module arp_cache_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  arpc_pkg::t_req              i_req,
    output logic                        o_busy,
    input  logic                        i_cfg_we,
    input  logic [arpc_pkg::TTL_W-1:0]  i_cfg_wdata,
    output logic                        o_done,
    output arpc_pkg::t_rsp              o_rsp
);
    import arpc_pkg::*;

    logic [IDX_W-1:0] rd_idx;
    t_entry           rd_entry;
    t_wr              wr;

    arpc_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .i_wr     (wr),
        .o_rd     (rd_entry)
    );

    arpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rd        (rd_entry),
        .o_rd_idx    (rd_idx),
        .o_wr        (wr),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== src/arpc_store.sv =====
// ----------------------------------------------------------------------------
// arpc_store
// Entry storage: IP, MAC and lifetime per entry, one read index, one write
// port with separate field enables. Reset clears every entry.
// ----------------------------------------------------------------------------
module arpc_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [arpc_pkg::IDX_W-1:0]  i_rd_idx,
    input  arpc_pkg::t_wr               i_wr,
    output arpc_pkg::t_entry            o_rd
);
    import arpc_pkg::*;

    logic [IP_W-1:0]  r_ip  [TABLE_ENTRIES];
    logic [MAC_W-1:0] r_mac [TABLE_ENTRIES];
    logic [TTL_W-1:0] r_ttl [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_ip[i]  <= '0;
                r_mac[i] <= '0;
                r_ttl[i] <= '0;
            end
        end else begin
            if (i_wr.ip_we)  r_ip[i_wr.idx]  <= i_wr.data.ip;
            if (i_wr.mac_we) r_mac[i_wr.idx] <= i_wr.data.mac;
            if (i_wr.ttl_we) r_ttl[i_wr.idx] <= i_wr.data.ttl;
        end
    end

    assign o_rd.ip  = r_ip[i_rd_idx];
    assign o_rd.mac = r_mac[i_rd_idx];
    assign o_rd.ttl = r_ttl[i_rd_idx];

endmodule

// ===== src/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer and shared compare unit: walks the entries one per cycle,
// matches the search key, tracks the first free entry, ages lifetimes,
// then commits learn writes and issues the response.
// ----------------------------------------------------------------------------
module arpc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  arpc_pkg::t_req              i_req,
    input  logic                        i_cfg_we,
    input  logic [arpc_pkg::TTL_W-1:0]  i_cfg_wdata,
    input  arpc_pkg::t_entry            i_rd,
    output logic [arpc_pkg::IDX_W-1:0]  o_rd_idx,
    output arpc_pkg::t_wr               o_wr,
    output logic                        o_busy,
    output logic                        o_done,
    output arpc_pkg::t_rsp              o_rsp
);
    import arpc_pkg::*;

    t_state            r_state, n_state;
    t_req              r_req;
    logic [IP_W-1:0]   r_key;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_match_idx, n_match_idx;
    logic [MAC_W-1:0]  r_mac, n_mac;
    logic              r_free_vld, n_free_vld;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [TTL_W-1:0]  r_lifetime;
    t_rsp              r_rsp, n_rsp;
    logic              r_done, n_done;

    logic              accept;
    logic              key_hit;
    logic              idx_last;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign key_hit  = (i_rd.ip == r_key);
    assign idx_last = (r_idx == IDX_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = (i_req.func == FN_NOP) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if ((key_hit && r_req.func != FN_TICK) || idx_last) n_state = ST_FINISH;
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx       = r_idx;
        n_found     = r_found;
        n_match_idx = r_match_idx;
        n_mac       = r_mac;
        n_free_vld  = r_free_vld;
        n_free_idx  = r_free_idx;
        n_rsp       = r_rsp;
        n_done      = 1'b0;
        o_wr        = '0;
        o_busy      = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (accept) begin
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_free_vld = 1'b0;
                end
            end
            ST_SCAN: begin
                n_idx = IDX_W'(r_idx + 1'b1);
                if (r_req.func == FN_TICK) begin
                    // age one entry per cycle
                    o_wr.ttl_we   = (i_rd.ttl != '0);
                    o_wr.idx      = r_idx;
                    o_wr.data.ttl = TTL_W'(i_rd.ttl - 1'b1);
                end else begin
                    if (key_hit) begin
                        n_found     = 1'b1;
                        n_match_idx = r_idx;
                        n_mac       = i_rd.mac;
                    end
                    if (!r_free_vld && i_rd.ttl == '0) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_idx;
                    end
                end
            end
            ST_FINISH: begin
                n_done = 1'b1;
                n_rsp  = '0;
                case (r_req.func)
                    FN_LEARN: begin
                        o_wr.data.ip  = r_req.ip_addr;
                        o_wr.data.mac = r_req.mac_addr;
                        o_wr.data.ttl = r_lifetime;
                        if (r_found) begin
                            o_wr.mac_we        = 1'b1;
                            o_wr.ttl_we        = 1'b1;
                            o_wr.idx           = r_match_idx;
                            n_rsp.hit          = 1'b1;
                            n_rsp.learn_status = LS_REFRESH;
                        end else if (r_free_vld) begin
                            o_wr.ip_we         = 1'b1;
                            o_wr.mac_we        = 1'b1;
                            o_wr.ttl_we        = 1'b1;
                            o_wr.idx           = r_free_idx;
                            n_rsp.learn_status = LS_INSERT;
                        end else begin
                            // drop the pair
                            n_rsp.learn_status = LS_FULL;
                        end
                    end
                    FN_LOOKUP: begin
                        n_rsp.hit      = r_found;
                        n_rsp.dest_mac = r_found ? r_mac : MAC_BCAST;
                    end
                    default: n_rsp = '0;
                endcase
            end
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_done     <= 1'b0;
            r_lifetime <= LIFETIME_RST;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) r_lifetime <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_key <= (i_req.func == FN_LOOKUP && i_req.next_hop_ip != '0)
                     ? i_req.next_hop_ip : i_req.ip_addr;
        end
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_match_idx <= n_match_idx;
        r_mac       <= n_mac;
        r_free_vld  <= n_free_vld;
        r_free_idx  <= n_free_idx;
        r_rsp       <= n_rsp;
    end

    assign o_rd_idx = r_idx;
    assign o_done   = r_done;
    assign o_rsp    = r_rsp;

    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_FINISH))
        else $error("response strobe without a finish cycle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("accepted request did not start");

    a_refresh_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_req.func == FN_LEARN && o_wr.ip_we) |-> !r_found)
        else $error("insert issued although the IP matched");

    a_full_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_rsp.learn_status == LS_FULL) |-> $past(!r_free_vld && !r_found))
        else $error("learn dropped while an entry was free");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for arp_cache_table. A behavioral copy of the cache
// (entries, lifetimes, lifetime register) predicts every response at the
// edge that takes the request. A monitor compares each strobed response with
// the oldest prediction. Directed tests cover the cleared table, the zero and
// short lifetime settings, refresh, insert and the full table. Random traffic
// over a small IP pool then runs under several lifetime settings with random
// sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import arpc_pkg::*;

    localparam int POOL_N = 12;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_start     = 1'b0;
    t_req       i_req       = '0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       o_busy;
    logic       o_done;
    t_rsp       o_rsp;

    arp_cache_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // cache copy used for prediction
    logic [IP_W-1:0]  tbl_ip  [TABLE_ENTRIES];
    logic [MAC_W-1:0] tbl_mac [TABLE_ENTRIES];
    logic [TTL_W-1:0] tbl_ttl [TABLE_ENTRIES];
    logic [TTL_W-1:0] lifetime_reg;
    logic [IP_W-1:0]  ip_pool [POOL_N];

    t_rsp exp_rsp_q[$];
    int   err_count;
    int   rsp_checked;
    int   n_learn, n_lookup, n_tick, n_nop;
    int   n_refresh, n_insert, n_full, n_hit;

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_ip[i]  = '0;
            tbl_mac[i] = '0;
            tbl_ttl[i] = '0;
        end
        lifetime_reg = LIFETIME_RST;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    function automatic int find_entry(logic [IP_W-1:0] ip);
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_ip[i] == ip) return i;
        end
        return -1;
    endfunction

    // Apply one request to the cache copy and return the response it gives.
    function automatic t_rsp predict_arp_rsp(t_req r);
        t_rsp            rsp;
        int              idx;
        int              i;
        logic [IP_W-1:0] key;
        rsp = '0;
        case (r.func)
            FN_LEARN: begin
                n_learn++;
                idx = find_entry(r.ip_addr);
                if (idx >= 0) begin
                    tbl_mac[idx]     = r.mac_addr;
                    tbl_ttl[idx]     = lifetime_reg;
                    rsp.hit          = 1'b1;
                    rsp.learn_status = LS_REFRESH;
                    n_refresh++;
                end else begin
                    rsp.learn_status = LS_FULL;
                    for (i = 0; i < TABLE_ENTRIES; i++) begin
                        if (tbl_ttl[i] == '0) begin
                            tbl_ip[i]        = r.ip_addr;
                            tbl_mac[i]       = r.mac_addr;
                            tbl_ttl[i]       = lifetime_reg;
                            rsp.learn_status = LS_INSERT;
                            break;
                        end
                    end
                    if (rsp.learn_status == LS_INSERT) n_insert++;
                    else n_full++;
                end
            end
            FN_LOOKUP: begin
                n_lookup++;
                key = (r.next_hop_ip != '0) ? r.next_hop_ip : r.ip_addr;
                idx = find_entry(key);
                if (idx >= 0) begin
                    rsp.hit      = 1'b1;
                    rsp.dest_mac = tbl_mac[idx];
                    n_hit++;
                end else begin
                    rsp.dest_mac = MAC_BCAST;
                end
            end
            FN_TICK: begin
                n_tick++;
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_ttl[i] != '0) tbl_ttl[i] = tbl_ttl[i] - 1'b1;
                end
            end
            default: n_nop++;
        endcase
        return rsp;
    endfunction

    // response monitor
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (exp_rsp_q.size() == 0) begin
                report_mismatch("unexpected response", 64'(o_rsp), '0);
            end else begin
                want = exp_rsp_q.pop_front();
                rsp_checked++;
                if (o_rsp.hit !== want.hit)
                    report_mismatch("hit", 64'(o_rsp.hit), 64'(want.hit));
                if (o_rsp.dest_mac !== want.dest_mac)
                    report_mismatch("dest_mac", 64'(o_rsp.dest_mac), 64'(want.dest_mac));
                if (o_rsp.learn_status !== want.learn_status)
                    report_mismatch("learn_status", 64'(o_rsp.learn_status),
                                    64'(want.learn_status));
            end
        end
    end

    function automatic t_req mk_req(t_func f, logic [IP_W-1:0] ip,
                                    logic [IP_W-1:0] nh, logic [MAC_W-1:0] mac);
        t_req r;
        r.func        = f;
        r.ip_addr     = ip;
        r.next_hop_ip = nh;
        r.mac_addr    = mac;
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(t_req r);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
        exp_rsp_q.push_back(predict_arp_rsp(r));
    endtask

    task automatic idle_sender(int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (exp_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_lifetime(logic [7:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        lifetime_reg = v;
    endtask

    // cleared table: every entry holds IP 0, so IP 0 hits entry 0
    task automatic test_cleared_table();
        send_request(mk_req(FN_LOOKUP, '0, '0, rand_mac()));
        send_request(mk_req(FN_LOOKUP, 32'hC0A8_0001, '0, rand_mac()));
        send_request(mk_req(FN_TICK, '1, '1, '1));
        send_request(mk_req(FN_NOP, '1, '1, '1));
    endtask

    // zero lifetime: a learned entry is free again at once but stays matchable
    task automatic test_zero_lifetime();
        write_lifetime(8'd0);
        send_request(mk_req(FN_LEARN, 32'h0A00_0001, '0, 48'h0011_2233_4455));
        send_request(mk_req(FN_LEARN, 32'h0A00_0002, '0, 48'h0066_7788_99AA));
        send_request(mk_req(FN_LOOKUP, 32'h0A00_0001, '0, '0));
        send_request(mk_req(FN_LOOKUP, '1, 32'h0A00_0002, '0));
        send_request(mk_req(FN_LEARN, 32'h0A00_0002, '0, '1));
    endtask

    // lifetime of one: a single tick frees the entry, lookup still hits
    task automatic test_short_lifetime();
        write_lifetime(8'd1);
        send_request(mk_req(FN_LEARN, 32'h0A00_0003, '0, 48'hAAAA_5555_AAAA));
        send_request(mk_req(FN_LEARN, 32'h0A00_0004, '0, 48'h5555_AAAA_5555));
        send_request(mk_req(FN_TICK, '0, '0, '0));
        send_request(mk_req(FN_LOOKUP, 32'h0A00_0004, '0, '0));
        send_request(mk_req(FN_LEARN, 32'h0A00_0005, '0, rand_mac()));
    endtask

    // long lifetime: refresh, extremes, IP 0 refresh, fill and overflow
    task automatic test_learn_fill();
        write_lifetime(8'd255);
        send_request(mk_req(FN_LEARN, '1, '0, '1));
        send_request(mk_req(FN_LEARN, '1, '1, 48'h0));
        send_request(mk_req(FN_LOOKUP, '0, '1, '1));
        send_request(mk_req(FN_LEARN, '0, '0, 48'h0102_0304_0506));
        send_request(mk_req(FN_LOOKUP, '0, '0, '0));
        for (int k = 0; k < TABLE_ENTRIES; k++)
            send_request(mk_req(FN_LEARN, 32'hC0A8_0100 + k, '0, rand_mac()));
        send_request(mk_req(FN_LOOKUP, 32'h1234_5678, 32'hC0A8_0100 + TABLE_ENTRIES - 1, '0));
    endtask

    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return ip_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    task automatic run_phase(int n_items, int idle_pct);
        t_req r;
        int   sel;
        for (int k = 0; k < POOL_N; k++) ip_pool[k] = $urandom();
        if ($urandom_range(0, 1)) ip_pool[0] = '0;
        for (int n = 0; n < n_items; n++) begin
            sel           = $urandom_range(0, 99);
            r.ip_addr     = pick_ip();
            r.next_hop_ip = $urandom();
            r.mac_addr    = rand_mac();
            if (sel < 35) begin
                r.func = FN_LEARN;
            end else if (sel < 75) begin
                r.func = FN_LOOKUP;
                r.next_hop_ip = $urandom_range(0, 1) ? '0 : pick_ip();
            end else if (sel < 95) begin
                r.func = FN_TICK;
            end else begin
                r.func = FN_NOP;
            end
            send_request(r);
            if ($urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 14));
        end
    endtask

    task automatic test_random_traffic();
        run_phase(110, 30);
        write_lifetime(8'($urandom_range(2, 30)));
        run_phase(110, 10);
        write_lifetime(8'd1);
        run_phase(110, 50);
        write_lifetime(8'd0);
        run_phase(110, 20);
        write_lifetime(LIFETIME_RST);
        run_phase(110, 0);
    endtask

    task automatic finish_run();
        wait_drained();
        repeat (TABLE_ENTRIES + 4) @(posedge i_clk);
        $display("Covered %0d learns (%0d refresh, %0d insert, %0d dropped), %0d lookups",
                 n_learn, n_refresh, n_insert, n_full, n_lookup);
        $display("(%0d hits), %0d ticks, %0d no-ops; %0d responses checked, %0d mismatches",
                 n_hit, n_tick, n_nop, rsp_checked, err_count);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cleared_table();
        test_zero_lifetime();
        test_short_lifetime();
        test_learn_fill();
        test_random_traffic();
        finish_run();
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d responses outstanding", exp_rsp_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
